// ----- rtl/core/rba_pkg.sv -----
`default_nettype none
package rba_pkg;

  localparam int TABLE_SLOTS_DEF = 16;

  localparam int MODE_W     = 2;
  localparam int ID_W       = 32;
  localparam int SIZE_W     = 48;
  localparam int CLM_W      = 32;
  localparam int MEM_W      = 48;
  localparam int MODS_W     = 5;
  localparam int INST_W     = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int HALF_MEM_W = MEM_W / 2;
  localparam int PROD_W     = INST_W + HALF_MEM_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADMIT_MOD  = 2'd0,
    MODE_ADMIT_INST = 2'd1,
    MODE_REL_INST   = 2'd2,
    MODE_REL_MOD    = 2'd3
  } mode_t;

  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MODULES   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ARTIFACT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLAIMS    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSTANCES = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MEMORY    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MODULES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARTIFACT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLAIMS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INSTANCES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MEMORY    = 3'd4;

  typedef enum logic [2:0] {
    CELL_NOP   = 3'd0,
    CELL_ALLOC = 3'd1,
    CELL_INC   = 3'd2,
    CELL_DEC   = 3'd3,
    CELL_FREE  = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic              vld;
    logic [ID_W-1:0]   id;
    logic              found;
    logic [CLM_W-1:0]  claims;
    logic [MEM_W-1:0]  mem;
    logic [INST_W-1:0] live;
    logic              has_free;
  } probe_t;

  typedef struct packed {
    cell_op_t         op;
    logic [ID_W-1:0]  handle;
    logic [CLM_W-1:0] claims;
    logic [MEM_W-1:0] mem;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/rba_in_if.sv -----
`default_nettype none
interface rba_in_if;
  logic                        valid;
  logic                        ready;
  logic [rba_pkg::MODE_W-1:0]  mode;
  logic [rba_pkg::ID_W-1:0]    reservation_id;
  logic [rba_pkg::SIZE_W-1:0]  artifact_size;
  logic [rba_pkg::CLM_W-1:0]   claims;
  logic [rba_pkg::MEM_W-1:0]   memory_need;

  modport source (output valid, mode, reservation_id, artifact_size, claims, memory_need,
                  input ready);
  modport sink (input valid, mode, reservation_id, artifact_size, claims, memory_need,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rba_out_if.sv -----
`default_nettype none
interface rba_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [rba_pkg::ID_W-1:0]    granted_id;
  logic [rba_pkg::KIND_W-1:0]  decline_kind;
  logic [rba_pkg::MODS_W-1:0]  used_modules;
  logic [rba_pkg::CLM_W-1:0]   used_claims;
  logic [rba_pkg::INST_W-1:0]  used_instances;
  logic [rba_pkg::MEM_W-1:0]   used_memory;

  modport source (output valid, accepted, granted_id, decline_kind, used_modules,
                  used_claims, used_instances, used_memory, input ready);
  modport sink (input valid, accepted, granted_id, decline_kind, used_modules,
                used_claims, used_instances, used_memory, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rba_cell.sv -----
`default_nettype none
module rba_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rba_pkg::probe_t      tok_i,
  input  wire [IDX_W-1:0]      fidx_i,
  input  wire [IDX_W-1:0]      free_idx_i,
  output rba_pkg::probe_t      tok_o,
  output logic [IDX_W-1:0]     fidx_o,
  output logic [IDX_W-1:0]     free_idx_o,
  input  rba_pkg::cell_cmd_t   cmd_i,
  input  wire [IDX_W-1:0]      cmd_idx_i
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic                          valid_r;
  logic [rba_pkg::ID_W-1:0]      handle_r;
  logic [rba_pkg::CLM_W-1:0]     claims_r;
  logic [rba_pkg::MEM_W-1:0]     mem_r;
  logic [rba_pkg::INST_W-1:0]    live_r;

  rba_pkg::probe_t               tok_r, tok_nxt;
  logic [IDX_W-1:0]              fidx_r, fidx_nxt;
  logic [IDX_W-1:0]              free_idx_r, free_idx_nxt;
  logic                          hit;

  assign hit = (cmd_i.op != rba_pkg::CELL_NOP) && (cmd_idx_i == MyIdx);

  // match the lowest valid slot, pick the lowest free slot
  always_comb begin
    tok_nxt      = tok_i;
    fidx_nxt     = fidx_i;
    free_idx_nxt = free_idx_i;
    if (!tok_i.found && valid_r && handle_r == tok_i.id) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.claims = claims_r;
      tok_nxt.mem    = mem_r;
      tok_nxt.live   = live_r;
      fidx_nxt       = MyIdx;
    end
    if (!tok_i.has_free && !valid_r) begin
      tok_nxt.has_free = 1'b1;
      free_idx_nxt     = MyIdx;
    end
  end

  always_ff @(posedge clk) begin
    fidx_r     <= fidx_nxt;
    free_idx_r <= free_idx_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (hit && cmd_i.op == rba_pkg::CELL_ALLOC) begin
      valid_r <= 1'b1;
    end else if (hit && cmd_i.op == rba_pkg::CELL_FREE) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      case (cmd_i.op)
        rba_pkg::CELL_ALLOC: begin
          handle_r <= cmd_i.handle;
          claims_r <= cmd_i.claims;
          mem_r    <= cmd_i.mem;
          live_r   <= '0;
        end
        rba_pkg::CELL_INC: begin
          live_r <= live_r + rba_pkg::INST_W'(1);
        end
        rba_pkg::CELL_DEC: begin
          live_r <= live_r - rba_pkg::INST_W'(1);
        end
        rba_pkg::CELL_FREE: begin
          live_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign tok_o      = tok_r;
  assign fidx_o     = fidx_r;
  assign free_idx_o = free_idx_r;

endmodule
`default_nettype wire

// ----- rtl/core/resource_budget_admission_top.sv -----
`default_nettype none
// Admission controller over a table of TABLE_SLOTS module slots. Each request beat
// (admit module, admit instance, release instance, release module) yields exactly one
// result beat with the acceptance, granted handle, decline kind and the usage totals
// after the request. One request is in work at a time. Each passes a probe that walks
// the chain of slot cells one cell per cycle, then a check state that also forms the
// partial products for the release-module memory charge, a multiply state that sums
// them, a decide state that writes the result register and the chosen slot, and the
// idle state that takes the next beat. A result still waiting at the decide state
// holds that state until it is taken. Limit registers are written through the cfg
// port while idle; that is for the user to keep to, the block itself does not
// enforce it.
module resource_budget_admission_top #(
  parameter int TABLE_SLOTS = rba_pkg::TABLE_SLOTS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [rba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [rba_pkg::CFG_DATA_W-1:0]    cfg_data,
  rba_in_if.sink                           in_ch,
  rba_out_if.source                        out_ch
);

  localparam int IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_MUL,
    ST_DECIDE
  } state_t;

  state_t state_r;

  logic [rba_pkg::MODS_W-1:0]  max_mod_r;
  logic [rba_pkg::SIZE_W-1:0]  max_art_r;
  logic [rba_pkg::CLM_W-1:0]   max_clm_r;
  logic [rba_pkg::INST_W-1:0]  max_inst_r;
  logic [rba_pkg::MEM_W-1:0]   max_mem_r;

  rba_pkg::mode_t              mode_r;
  logic [rba_pkg::ID_W-1:0]    id_r;
  logic [rba_pkg::SIZE_W-1:0]  art_r;
  logic [rba_pkg::CLM_W-1:0]   clm_r;
  logic [rba_pkg::MEM_W-1:0]   mem_r;

  logic                        sc_found_r;
  logic [IdxW-1:0]             sc_idx_r;
  logic [rba_pkg::CLM_W-1:0]   sc_claims_r;
  logic [rba_pkg::MEM_W-1:0]   sc_mem_r;
  logic [rba_pkg::INST_W-1:0]  sc_live_r;
  logic                        sc_free_r;
  logic [IdxW-1:0]             sc_free_idx_r;

  logic                        mod_full_r, art_over_r, clm_over_r, inst_full_r, mem_over_r;
  logic [rba_pkg::PROD_W-1:0]  mul_lo_r, mul_hi_r;
  logic [rba_pkg::MEM_W-1:0]   rel_mem_r;

  logic [rba_pkg::ID_W-1:0]    next_id_r, next_id_nxt;
  logic [rba_pkg::MODS_W-1:0]  tot_mod_r, tot_mod_nxt;
  logic [rba_pkg::CLM_W-1:0]   tot_clm_r, tot_clm_nxt;
  logic [rba_pkg::INST_W-1:0]  tot_inst_r, tot_inst_nxt;
  logic [rba_pkg::MEM_W-1:0]   tot_mem_r, tot_mem_nxt;

  logic                        out_valid_r;
  logic                        acc_r, acc_nxt;
  logic [rba_pkg::ID_W-1:0]    gid_r, gid_nxt;
  logic [rba_pkg::KIND_W-1:0]  kind_r, kind_nxt;

  rba_pkg::probe_t             tok [TABLE_SLOTS+1];
  logic [IdxW-1:0]             fidx [TABLE_SLOTS+1];
  logic [IdxW-1:0]             free_idx [TABLE_SLOTS+1];

  rba_pkg::cell_cmd_t          cmd, cmd_sel;
  logic [IdxW-1:0]             cmd_idx;

  logic                        in_fire;
  logic                        go;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign go          = (state_r == ST_DECIDE) && (!out_valid_r || out_ch.ready);

  // launch the probe into the first cell
  always_comb begin
    tok[0]          = '0;
    tok[0].vld      = in_fire;
    tok[0].id       = in_ch.reservation_id;
    fidx[0]         = '0;
    free_idx[0]     = '0;
  end

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    rba_cell #(
      .IDX_W    (IdxW),
      .CELL_IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok[g]),
      .fidx_i     (fidx[g]),
      .free_idx_i (free_idx[g]),
      .tok_o      (tok[g+1]),
      .fidx_o     (fidx[g+1]),
      .free_idx_o (free_idx[g+1]),
      .cmd_i      (cmd),
      .cmd_idx_i  (cmd_idx)
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mod_r  <= '0;
      max_art_r  <= '0;
      max_clm_r  <= '0;
      max_inst_r <= '0;
      max_mem_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rba_pkg::CFG_MAX_MODULES:   max_mod_r  <= cfg_data[rba_pkg::MODS_W-1:0];
        rba_pkg::CFG_MAX_ARTIFACT:  max_art_r  <= cfg_data[rba_pkg::SIZE_W-1:0];
        rba_pkg::CFG_MAX_CLAIMS:    max_clm_r  <= cfg_data[rba_pkg::CLM_W-1:0];
        rba_pkg::CFG_MAX_INSTANCES: max_inst_r <= cfg_data[rba_pkg::INST_W-1:0];
        rba_pkg::CFG_MAX_MEMORY:    max_mem_r  <= cfg_data[rba_pkg::MEM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    acc_nxt          = 1'b0;
    gid_nxt          = '0;
    kind_nxt         = rba_pkg::KIND_NONE;
    next_id_nxt      = next_id_r;
    tot_mod_nxt      = tot_mod_r;
    tot_clm_nxt      = tot_clm_r;
    tot_inst_nxt     = tot_inst_r;
    tot_mem_nxt      = tot_mem_r;
    cmd_sel.op       = rba_pkg::CELL_NOP;
    cmd_sel.handle   = next_id_r;
    cmd_sel.claims   = clm_r;
    cmd_sel.mem      = mem_r;
    cmd_idx          = sc_idx_r;
    if (mode_r == rba_pkg::MODE_ADMIT_MOD) begin
      cmd_idx = sc_free_idx_r;
      if (mod_full_r) begin
        kind_nxt = rba_pkg::KIND_MODULES;
      end else if (art_over_r) begin
        kind_nxt = rba_pkg::KIND_ARTIFACT;
      end else if (clm_over_r) begin
        kind_nxt = rba_pkg::KIND_CLAIMS;
      end else begin
        acc_nxt     = 1'b1;
        gid_nxt     = next_id_r;
        cmd_sel.op  = rba_pkg::CELL_ALLOC;
        next_id_nxt = next_id_r + rba_pkg::ID_W'(1);
        tot_mod_nxt = tot_mod_r + rba_pkg::MODS_W'(1);
        tot_clm_nxt = tot_clm_r + clm_r;
      end
    end else if (!sc_found_r) begin
      kind_nxt = rba_pkg::KIND_UNKNOWN;
    end else begin
      case (mode_r)
        rba_pkg::MODE_ADMIT_INST: begin
          if (inst_full_r) begin
            kind_nxt = rba_pkg::KIND_INSTANCES;
          end else if (mem_over_r) begin
            kind_nxt = rba_pkg::KIND_MEMORY;
          end else begin
            acc_nxt      = 1'b1;
            gid_nxt      = id_r;
            cmd_sel.op   = rba_pkg::CELL_INC;
            tot_inst_nxt = tot_inst_r + rba_pkg::INST_W'(1);
            tot_mem_nxt  = tot_mem_r + sc_mem_r;
          end
        end
        rba_pkg::MODE_REL_INST: begin
          if (sc_live_r != '0) begin
            acc_nxt      = 1'b1;
            cmd_sel.op   = rba_pkg::CELL_DEC;
            tot_inst_nxt = tot_inst_r - rba_pkg::INST_W'(1);
            tot_mem_nxt  = tot_mem_r - sc_mem_r;
          end
        end
        rba_pkg::MODE_REL_MOD: begin
          acc_nxt      = 1'b1;
          cmd_sel.op   = rba_pkg::CELL_FREE;
          tot_inst_nxt = tot_inst_r - sc_live_r;
          tot_mem_nxt  = tot_mem_r - rel_mem_r;
          tot_mod_nxt  = tot_mod_r - rba_pkg::MODS_W'(1);
          tot_clm_nxt  = tot_clm_r - sc_claims_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cmd = cmd_sel;
    if (!go) begin
      cmd.op = rba_pkg::CELL_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      next_id_r   <= rba_pkg::ID_W'(1);
      tot_mod_r   <= '0;
      tot_clm_r   <= '0;
      tot_inst_r  <= '0;
      tot_mem_r   <= '0;
    end else begin
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok[TABLE_SLOTS].vld) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (go) begin
            state_r    <= ST_IDLE;
            next_id_r  <= next_id_nxt;
            tot_mod_r  <= tot_mod_nxt;
            tot_clm_r  <= tot_clm_nxt;
            tot_inst_r <= tot_inst_nxt;
            tot_mem_r  <= tot_mem_nxt;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= rba_pkg::mode_t'(in_ch.mode);
      id_r   <= in_ch.reservation_id;
      art_r  <= in_ch.artifact_size;
      clm_r  <= in_ch.claims;
      mem_r  <= in_ch.memory_need;
    end
    if (state_r == ST_SCAN && tok[TABLE_SLOTS].vld) begin
      sc_found_r    <= tok[TABLE_SLOTS].found;
      sc_idx_r      <= fidx[TABLE_SLOTS];
      sc_claims_r   <= tok[TABLE_SLOTS].claims;
      sc_mem_r      <= tok[TABLE_SLOTS].mem;
      sc_live_r     <= tok[TABLE_SLOTS].live;
      sc_free_r     <= tok[TABLE_SLOTS].has_free;
      sc_free_idx_r <= free_idx[TABLE_SLOTS];
    end
    if (state_r == ST_CHECK) begin
      mod_full_r  <= (tot_mod_r >= max_mod_r) || !sc_free_r;
      art_over_r  <= art_r > max_art_r;
      clm_over_r  <= (tot_clm_r > max_clm_r) || (clm_r > (max_clm_r - tot_clm_r));
      inst_full_r <= tot_inst_r >= max_inst_r;
      mem_over_r  <= (tot_mem_r > max_mem_r) || (sc_mem_r > (max_mem_r - tot_mem_r));
      mul_lo_r    <= rba_pkg::PROD_W'(sc_live_r)
                     * rba_pkg::PROD_W'(sc_mem_r[rba_pkg::HALF_MEM_W-1:0]);
      mul_hi_r    <= rba_pkg::PROD_W'(sc_live_r)
                     * rba_pkg::PROD_W'(sc_mem_r[rba_pkg::MEM_W-1:rba_pkg::HALF_MEM_W]);
    end
    if (state_r == ST_MUL) begin
      rel_mem_r <= rba_pkg::MEM_W'(mul_lo_r)
                   + {mul_hi_r[rba_pkg::HALF_MEM_W-1:0], {rba_pkg::HALF_MEM_W{1'b0}}};
    end
    if (go) begin
      acc_r  <= acc_nxt;
      gid_r  <= gid_nxt;
      kind_r <= kind_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = acc_r;
  assign out_ch.granted_id     = gid_r;
  assign out_ch.decline_kind   = kind_r;
  assign out_ch.used_modules   = tot_mod_r;
  assign out_ch.used_claims    = tot_clm_r;
  assign out_ch.used_instances = tot_inst_r;
  assign out_ch.used_memory    = tot_mem_r;

endmodule
`default_nettype wire

// ----- rtl/core/rba_chk.sv -----
`default_nettype none
module rba_chk (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_ready,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire                             out_accepted,
  input wire [rba_pkg::ID_W-1:0]         out_granted_id,
  input wire [rba_pkg::KIND_W-1:0]       out_decline_kind,
  input wire [rba_pkg::MODS_W-1:0]       out_used_modules
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_id)
      && $stable(out_decline_kind) && $stable(out_used_modules))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_decline_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decline_kind != rba_pkg::KIND_NONE |-> !out_accepted
      && out_granted_id == '0)
    else $error("declined beat carries acceptance or handle");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_decline_kind != 3'd7)
    else $error("decline kind out of range");

endmodule

bind resource_budget_admission_top rba_chk u_rba_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_accepted     (out_ch.accepted),
  .out_granted_id   (out_ch.granted_id),
  .out_decline_kind (out_ch.decline_kind),
  .out_used_modules (out_ch.used_modules)
);
`default_nettype wire

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rba_pkg::*;

  localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] M32 = 32'hFFFF_FFFF;

  typedef struct packed {
    mode_t             mode;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] art;
    logic [CLM_W-1:0]  clm;
    logic [MEM_W-1:0]  mem;
  } request_t;

  typedef struct packed {
    logic              accepted;
    logic [ID_W-1:0]   granted_id;
    logic [KIND_W-1:0] kind;
    logic [MODS_W-1:0] mods;
    logic [CLM_W-1:0]  clm;
    logic [INST_W-1:0] inst;
    logic [MEM_W-1:0]  mem;
  } verdict_t;

  typedef struct {
    bit          is_cfg;
    logic [4:0]  l_mods;
    logic [47:0] l_art;
    logic [31:0] l_clm;
    logic [15:0] l_inst;
    logic [47:0] l_mem;
    request_t    req;
    bit          typed;
    verdict_t    want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rba_in_if  in_ch ();
  rba_out_if out_ch ();

  resource_budget_admission_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // budget limits as last written
  logic [4:0]  lim_mods = '0;
  logic [47:0] lim_art  = '0;
  logic [31:0] lim_clm  = '0;
  logic [15:0] lim_inst = '0;
  logic [47:0] lim_mem  = '0;

  // reservation table and totals
  logic [31:0] hnd_next = 32'd1;
  bit          slot_used [TABLE_SLOTS];
  logic [31:0] slot_hnd  [TABLE_SLOTS];
  logic [31:0] slot_clm  [TABLE_SLOTS];
  logic [47:0] slot_mem  [TABLE_SLOTS];
  logic [15:0] slot_live [TABLE_SLOTS];
  logic [4:0]  tot_mods = '0;
  logic [31:0] tot_clm  = '0;
  logic [15:0] tot_inst = '0;
  logic [47:0] tot_mem  = '0;

  verdict_t  outcome_q [$];
  plan_row_t plan [$];

  bit       idle_on = 1'b1;
  bit       note_typed = 1'b0;
  verdict_t note_want = '0;

  int errors = 0;
  int sent_count = 0;
  int directed_count = 0;
  int checked_count = 0;
  int granted_count = 0;
  int kind_hits [8];
  int quiet_cycles = 0;
  int src_calm = 0;

  verdict_t got;
  verdict_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit exceeds(logic [63:0] cur, logic [63:0] add, logic [63:0] lim);
    return cur > lim || add > lim - cur;
  endfunction

  function automatic verdict_t apply_request(request_t r);
    verdict_t    v;
    int          s;
    int          i;
    logic [63:0] prod;
    v = '0;
    s = -1;
    if (r.mode == MODE_ADMIT_MOD) begin
      for (i = TABLE_SLOTS - 1; i >= 0; i--) begin
        if (!slot_used[i]) s = i;
      end
      if (tot_mods >= lim_mods || s < 0) begin
        v.kind = KIND_MODULES;
      end else if (r.art > lim_art) begin
        v.kind = KIND_ARTIFACT;
      end else if (exceeds(64'(tot_clm), 64'(r.clm), 64'(lim_clm))) begin
        v.kind = KIND_CLAIMS;
      end else begin
        slot_used[s] = 1'b1;
        slot_hnd[s]  = hnd_next;
        slot_clm[s]  = r.clm;
        slot_mem[s]  = r.mem;
        slot_live[s] = '0;
        v.granted_id = hnd_next;
        hnd_next     = hnd_next + 32'd1;
        tot_mods     = tot_mods + 5'd1;
        tot_clm      = tot_clm + r.clm;
        v.accepted   = 1'b1;
      end
    end else begin
      for (i = TABLE_SLOTS - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_hnd[i] == r.id) s = i;
      end
      if (s < 0) begin
        v.kind = KIND_UNKNOWN;
      end else if (r.mode == MODE_ADMIT_INST) begin
        if (tot_inst >= lim_inst) begin
          v.kind = KIND_INSTANCES;
        end else if (exceeds(64'(tot_mem), 64'(slot_mem[s]), 64'(lim_mem))) begin
          v.kind = KIND_MEMORY;
        end else begin
          slot_live[s] = slot_live[s] + 16'd1;
          tot_inst     = tot_inst + 16'd1;
          tot_mem      = tot_mem + slot_mem[s];
          v.granted_id = r.id;
          v.accepted   = 1'b1;
        end
      end else if (r.mode == MODE_REL_INST) begin
        if (slot_live[s] != 0) begin
          slot_live[s] = slot_live[s] - 16'd1;
          tot_inst     = tot_inst - 16'd1;
          tot_mem      = tot_mem - slot_mem[s];
          v.accepted   = 1'b1;
        end
      end else begin
        prod         = 64'(slot_live[s]) * 64'(slot_mem[s]);
        tot_inst     = tot_inst - slot_live[s];
        tot_mem      = tot_mem - prod[47:0];
        tot_mods     = tot_mods - 5'd1;
        tot_clm      = tot_clm - slot_clm[s];
        slot_used[s] = 1'b0;
        slot_live[s] = '0;
        v.accepted   = 1'b1;
      end
    end
    v.mods = tot_mods;
    v.clm  = tot_clm;
    v.inst = tot_inst;
    v.mem  = tot_mem;
    return v;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic [47:0] field_pick(logic [47:0] lim, int unsigned div);
    logic [47:0] w;
    logic [63:0] span;
    w = rand48();
    span = {16'd0, lim} / div + 64'd1;
    case ($urandom_range(0, 9))
      0: return w;
      1: return lim;
      2: return lim + 48'd1;
      default: return 48'(64'(w) % span);
    endcase
  endfunction

  function automatic logic [47:0] pick_limit(logic [47:0] top);
    case ($urandom_range(0, 3))
      0: return top;
      1: return rand48() & top;
      default: return 48'($urandom_range(1, 100000));
    endcase
  endfunction

  function automatic logic [31:0] pick_handle();
    int live_idx [$];
    int i;
    int r;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_used[i]) live_idx.push_back(i);
    end
    r = $urandom_range(0, 19);
    if (r < 17 && live_idx.size() > 0)
      return slot_hnd[live_idx[$urandom_range(0, live_idx.size() - 1)]];
    if (r < 19) return $urandom;
    return hnd_next - 32'd1;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick  = $urandom_range(0, 99);
    r.id  = $urandom;
    r.art = rand48();
    r.clm = $urandom;
    r.mem = rand48();
    if (pick < 5) begin
      r.mode = mode_t'($urandom_range(0, 3));
    end else if (pick < 35) begin
      r.mode = MODE_ADMIT_MOD;
      r.art  = field_pick(lim_art, 1);
      r.clm  = 32'(field_pick(48'(lim_clm), 8));
      r.mem  = field_pick(lim_mem, 8);
    end else begin
      if (pick < 65) r.mode = MODE_ADMIT_INST;
      else if (pick < 85) r.mode = MODE_REL_INST;
      else r.mode = MODE_REL_MOD;
      r.id = pick_handle();
    end
    return r;
  endfunction

  function automatic void add_limits(logic [4:0] m, logic [47:0] a, logic [31:0] c,
                                     logic [15:0] n, logic [47:0] b);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.l_mods = m;
    row.l_art  = a;
    row.l_clm  = c;
    row.l_inst = n;
    row.l_mem  = b;
    plan.push_back(row);
  endfunction

  function automatic void add_req(mode_t md, logic [31:0] id, logic [47:0] a,
                                  logic [31:0] c, logic [47:0] b);
    plan_row_t row;
    row = '{default: '0};
    row.req = '{mode: md, id: id, art: a, clm: c, mem: b};
    plan.push_back(row);
  endfunction

  function automatic void add_chk(mode_t md, logic [31:0] id, logic [47:0] a,
                                  logic [31:0] c, logic [47:0] b,
                                  logic acc, logic [31:0] gid, logic [2:0] kind,
                                  logic [4:0] um, logic [31:0] uc, logic [15:0] ui,
                                  logic [47:0] ub);
    plan_row_t row;
    row = '{default: '0};
    row.req   = '{mode: md, id: id, art: a, clm: c, mem: b};
    row.typed = 1'b1;
    row.want  = '{accepted: acc, granted_id: gid, kind: kind, mods: um, clm: uc,
                  inst: ui, mem: ub};
    plan.push_back(row);
  endfunction

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
  endtask

  // drain the block before touching the limits
  task automatic write_limits(logic [4:0] m, logic [47:0] a, logic [31:0] c,
                              logic [15:0] n, logic [47:0] b);
    in_ch.valid = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (TABLE_SLOTS + 5) @(negedge clk);
    put_reg(CFG_MAX_MODULES, 48'(m));
    put_reg(CFG_MAX_ARTIFACT, a);
    put_reg(CFG_MAX_CLAIMS, 48'(c));
    put_reg(CFG_MAX_INSTANCES, 48'(n));
    put_reg(CFG_MAX_MEMORY, b);
    cfg_we   = 1'b0;
    lim_mods = m;
    lim_art  = a;
    lim_clm  = c;
    lim_inst = n;
    lim_mem  = b;
  endtask

  task automatic send_beat(request_t r, bit typed, verdict_t w);
    int gap;
    gap = 0;
    if (idle_on && src_calm == 0 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      if ($urandom_range(0, 2) == 0) src_calm = $urandom_range(10, 40);
    end else if (src_calm > 0) begin
      src_calm--;
    end
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.mode           = r.mode;
    in_ch.reservation_id = r.id;
    in_ch.artifact_size  = r.art;
    in_ch.claims         = r.clm;
    in_ch.memory_need    = r.mem;
    note_typed           = typed;
    note_want            = w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic compare_result(verdict_t w, verdict_t g);
    if (w.accepted !== g.accepted || w.granted_id !== g.granted_id ||
        w.kind !== g.kind || w.mods !== g.mods || w.clm !== g.clm ||
        w.inst !== g.inst || w.mem !== g.mem) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("mismatch at result %0d: want acc=%0d id=%0h kind=%0d mods=%0d",
                 checked_count, w.accepted, w.granted_id, w.kind, w.mods);
        $display("  clm=%0h inst=%0d mem=%0h | got acc=%0d id=%0h kind=%0d mods=%0d",
                 w.clm, w.inst, w.mem, g.accepted, g.granted_id, g.kind, g.mods);
        $display("  clm=%0h inst=%0d mem=%0h", g.clm, g.inst, g.mem);
      end
    end
  endtask

  // drop a result beat into the checker, then book the request beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.accepted   = out_ch.accepted;
        got.granted_id = out_ch.granted_id;
        got.kind       = out_ch.decline_kind;
        got.mods       = out_ch.used_modules;
        got.clm        = out_ch.used_claims;
        got.inst       = out_ch.used_instances;
        got.mem        = out_ch.used_memory;
        checked_count++;
        if (got.accepted === 1'b1) granted_count++;
        else if (!$isunknown(got.kind)) kind_hits[got.kind]++;
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result beat %0d arrived with nothing expected", checked_count);
        end else begin
          compare_result(outcome_q.pop_front(), got);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = apply_request('{mode: mode_t'(in_ch.mode), id: in_ch.reservation_id,
                               art: in_ch.artifact_size, clm: in_ch.claims,
                               mem: in_ch.memory_need});
        outcome_q.push_back(note_typed ? note_want : want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
          $display("no beat moved for %0d cycles, %0d results outstanding",
                   STALL_LIMIT, outcome_q.size());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (idle_on && calm == 0 && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        stall = $urandom_range(1, 4) - 1;
        if ($urandom_range(0, 3) == 0) calm = $urandom_range(20, 80);
      end else begin
        out_ch.ready = 1'b1;
        if (calm > 0) calm--;
      end
    end
  end

  initial begin
    int        i;
    int        p;
    int        k;
    int        n_items;
    plan_row_t row;

    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_hnd[i]  = '0;
      slot_clm[i]  = '0;
      slot_mem[i]  = '0;
      slot_live[i] = '0;
    end
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = '0;
    in_ch.reservation_id = '0;
    in_ch.artifact_size  = '0;
    in_ch.claims         = '0;
    in_ch.memory_need    = '0;

    add_chk(MODE_ADMIT_MOD, 32'hA5A5_0001, 0, 0, 0, 0, 0, KIND_MODULES, 0, 0, 0, 0);
    add_chk(MODE_ADMIT_INST, 1, M48, M32, M48, 0, 0, KIND_UNKNOWN, 0, 0, 0, 0);
    add_chk(MODE_REL_INST, M32, 0, 0, 0, 0, 0, KIND_UNKNOWN, 0, 0, 0, 0);
    add_chk(MODE_REL_MOD, 0, 0, 0, 0, 0, 0, KIND_UNKNOWN, 0, 0, 0, 0);
    add_limits(5'd16, M48, M32, 16'hFFFF, M48);
    add_chk(MODE_ADMIT_MOD, M32, M48, M32, 0, 1, 1, KIND_NONE, 1, M32, 0, 0);
    add_chk(MODE_ADMIT_MOD, 0, 0, 1, 5, 0, 0, KIND_CLAIMS, 1, M32, 0, 0);
    add_chk(MODE_ADMIT_MOD, 0, 0, 0, M48, 1, 2, KIND_NONE, 2, M32, 0, 0);
    add_chk(MODE_ADMIT_INST, 2, 0, 0, 0, 1, 2, KIND_NONE, 2, M32, 1, M48);
    add_chk(MODE_ADMIT_INST, 2, 0, 0, 0, 0, 0, KIND_MEMORY, 2, M32, 1, M48);
    add_chk(MODE_ADMIT_INST, 1, 0, 0, 0, 1, 1, KIND_NONE, 2, M32, 2, M48);
    add_req(MODE_REL_INST, 2, 0, 0, 0);
    add_chk(MODE_REL_INST, 2, 0, 0, 0, 0, 0, KIND_NONE, 2, M32, 1, 0);
    add_req(MODE_REL_MOD, 1, 0, 0, 0);
    add_limits(5'd2, 48'd100, 32'd10, 16'd1, 48'd1000);
    add_chk(MODE_ADMIT_MOD, 0, 101, 0, 0, 0, 0, KIND_ARTIFACT, 1, 0, 0, 0);
    add_chk(MODE_ADMIT_MOD, 0, 100, 11, 0, 0, 0, KIND_CLAIMS, 1, 0, 0, 0);
    add_req(MODE_ADMIT_MOD, 0, 100, 10, 600);
    add_chk(MODE_ADMIT_MOD, 0, M48, M32, M48, 0, 0, KIND_MODULES, 2, 10, 0, 0);
    add_req(MODE_ADMIT_INST, 3, 0, 0, 0);
    add_chk(MODE_ADMIT_INST, 3, 0, 0, 0, 0, 0, KIND_INSTANCES, 2, 10, 1, 600);
    add_limits(5'd31, 48'd100, 32'd5, 16'hFFFF, 48'd500);
    add_chk(MODE_ADMIT_MOD, 0, 0, 0, 0, 0, 0, KIND_CLAIMS, 2, 10, 1, 600);
    add_chk(MODE_ADMIT_INST, 3, 0, 0, 0, 0, 0, KIND_MEMORY, 2, 10, 1, 600);
    add_req(MODE_REL_MOD, 3, 0, 0, 0);
    add_req(MODE_REL_MOD, 2, 0, 0, 0);
    add_chk(MODE_REL_MOD, 3, 0, 0, 0, 0, 0, KIND_UNKNOWN, 0, 0, 0, 0);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        write_limits(row.l_mods, row.l_art, row.l_clm, row.l_inst, row.l_mem);
      end else begin
        send_beat(row.req, row.typed, row.want);
        directed_count++;
      end
    end

    for (p = 0; p < 8; p++) begin
      if (p == 7) idle_on = 1'b0;
      case (p)
        0: write_limits(5'd16, M48, M32, 16'hFFFF, M48);
        1: write_limits(5'd31, 48'd1000, 32'd100, 16'd8, 48'd5000);
        2: write_limits(5'd0, 48'd0, 32'd0, 16'd0, 48'd0);
        default: write_limits(5'($urandom_range(1, 31)), pick_limit(M48),
                              32'(pick_limit(48'(M32))),
                              ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : 16'($urandom_range(0, 40)),
                              pick_limit(M48));
      endcase
      n_items = (p == 2) ? 60 : 135;
      for (k = 0; k < n_items; k++) send_beat(random_request(), 1'b0, '0);
    end
    in_ch.valid = 1'b0;

    while (outcome_q.size() != 0) @(negedge clk);
    repeat (TABLE_SLOTS + 10) @(negedge clk);
    errors += outcome_q.size();

    $display("sent %0d requests (%0d directed) over 11 limit settings, checked %0d results",
             sent_count, directed_count, checked_count);
    $display("granted %0d; declined: modules %0d artifact %0d claims %0d instances %0d",
             granted_count, kind_hits[KIND_MODULES], kind_hits[KIND_ARTIFACT],
             kind_hits[KIND_CLAIMS], kind_hits[KIND_INSTANCES]);
    $display("  memory %0d unknown id %0d idle release %0d",
             kind_hits[KIND_MEMORY], kind_hits[KIND_UNKNOWN], kind_hits[KIND_NONE]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
